>>> rtl/hbrr_pkg.sv
// Shared types and constants for the HTTP byte range resolver.
package hbrr_pkg;

	// Width of body lengths and byte offsets
	localparam int LEN_W = 48;

	// Character codes the scanner looks for
	localparam logic [7:0] CH_CR    = 8'h0d;
	localparam logic [7:0] CH_LF    = 8'h0a;
	localparam logic [7:0] CH_SP    = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_COLON = 8'h3a;
	localparam logic [7:0] CH_COMMA = 8'h2c;
	localparam logic [7:0] CH_DASH  = 8'h2d;
	localparam logic [7:0] CH_0     = 8'h30;
	localparam logic [7:0] CH_9     = 8'h39;
	localparam logic [7:0] CH_UA    = 8'h41;
	localparam logic [7:0] CH_UZ    = 8'h5a;
	localparam logic [7:0] CH_CASE  = 8'h20;

	// Length of the header name and of the unit prefix
	localparam logic [2:0] NAME_LEN = 3'd5;
	localparam logic [2:0] PFX_LEN  = 3'd6;
	localparam logic [2:0] POS_MAX  = 3'd7;

	// Input word: one header byte
	typedef struct packed {
		logic [7:0]       req_byte;
		logic             req_end;
		logic [LEN_W-1:0] body_length;
	} hbrr_in_t;

	// Output word: resolved range
	typedef struct packed {
		logic [LEN_W-1:0] range_first;
		logic [LEN_W-1:0] range_last;
		logic             is_partial;
		logic             is_unsatisfiable;
	} hbrr_out_t;

	// Where the scanner stands within the header
	typedef enum logic [4:0] {
		LP_REQ   = 5'b00001,
		LP_NAME  = 5'b00010,
		LP_SKIP  = 5'b00100,
		LP_VALUE = 5'b01000,
		LP_DONE  = 5'b10000
	} line_phase_t;

	// Where the scanner stands within the Range value
	typedef enum logic [3:0] {
		VP_LWS    = 4'b0001,
		VP_PREFIX = 4'b0010,
		VP_BODY   = 4'b0100,
		VP_REJECT = 4'b1000
	} value_phase_t;

	// What the range text held
	typedef struct packed {
		logic dash;
		logic a_any;
		logic a_bad;
		logic b_any;
		logic b_bad;
		logic comma;
	} value_flags_t;

	// Scanner state
	typedef struct packed {
		line_phase_t      line_phase;
		logic [2:0]       name_pos;
		logic             name_mis;
		logic             committed;
		value_phase_t     value_phase;
		logic [2:0]       prefix_pos;
		logic [LEN_W-1:0] start_value;
		logic [LEN_W-1:0] end_value;
		value_flags_t     flags;
	} scan_t;

	// What the scanner hands over on the final byte
	typedef struct packed {
		logic             body_ok;
		logic [LEN_W-1:0] start_value;
		logic [LEN_W-1:0] end_value;
		value_flags_t     flags;
		logic [LEN_W-1:0] body_length;
	} snap_t;

endpackage

>>> rtl/hbrr_scan.sv
// Byte scanner: tracks header lines and accumulates the Range value.
module hbrr_scan (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            accept,
	input  hbrr_pkg::hbrr_in_t word,
	input  logic            load_s1,
	output hbrr_pkg::snap_t snap_s1
);

	hbrr_pkg::scan_t st_q;
	hbrr_pkg::scan_t st_n;
	hbrr_pkg::scan_t st_rst;
	logic            cr_q;
	logic            cr_n;

	function automatic logic [7:0] to_lower(input logic [7:0] c);
		if (c >= hbrr_pkg::CH_UA && c <= hbrr_pkg::CH_UZ) begin
			return c + hbrr_pkg::CH_CASE;
		end
		return c;
	endfunction

	function automatic logic [7:0] name_char(input logic [2:0] p);
		logic [7:0] r;
		unique case (p)
			3'd0: r = 8'h72; // r
			3'd1: r = 8'h61; // a
			3'd2: r = 8'h6e; // n
			3'd3: r = 8'h67; // g
			3'd4: r = 8'h65; // e
			default: r = 8'h00;
		endcase
		return r;
	endfunction

	function automatic logic [7:0] pfx_char(input logic [2:0] p);
		logic [7:0] r;
		unique case (p)
			3'd0: r = 8'h62; // b
			3'd1: r = 8'h79; // y
			3'd2: r = 8'h74; // t
			3'd3: r = 8'h65; // e
			3'd4: r = 8'h73; // s
			3'd5: r = 8'h3d; // =
			default: r = 8'h00;
		endcase
		return r;
	endfunction

	// Append one decimal digit, saturating at all ones
	function automatic logic [hbrr_pkg::LEN_W-1:0] dec_push(
		input logic [hbrr_pkg::LEN_W-1:0] v,
		input logic [3:0]                 d
	);
		logic [hbrr_pkg::LEN_W+3:0] t;
		t = ({4'b0, v} << 3) + ({4'b0, v} << 1) + {{hbrr_pkg::LEN_W{1'b0}}, d};
		if (t[hbrr_pkg::LEN_W+3:hbrr_pkg::LEN_W] != 4'd0) begin
			return {hbrr_pkg::LEN_W{1'b1}};
		end
		return t[hbrr_pkg::LEN_W-1:0];
	endfunction

	// Apply one ordinary line byte
	function automatic hbrr_pkg::scan_t content_step(
		input hbrr_pkg::scan_t s,
		input logic [7:0]      c
	);
		hbrr_pkg::scan_t       r;
		logic [7:0]            lc;
		logic                  is_dig;
		hbrr_pkg::value_phase_t vp;
		logic [2:0]            pp;
		r      = s;
		lc     = to_lower(c);
		is_dig = (c >= hbrr_pkg::CH_0) && (c <= hbrr_pkg::CH_9);
		vp     = s.value_phase;
		pp     = s.prefix_pos;
		if (s.line_phase == hbrr_pkg::LP_NAME) begin
			if (c == hbrr_pkg::CH_COLON) begin
				if (s.name_pos == hbrr_pkg::NAME_LEN && !s.name_mis) begin
					r.line_phase  = hbrr_pkg::LP_VALUE;
					r.value_phase = hbrr_pkg::VP_LWS;
					r.prefix_pos  = 3'd0;
					r.start_value = '0;
					r.end_value   = '0;
					r.flags       = '0;
				end else begin
					r.line_phase = hbrr_pkg::LP_SKIP;
				end
			end else begin
				if (s.name_pos >= hbrr_pkg::NAME_LEN || lc != name_char(s.name_pos)) begin
					r.name_mis = 1'b1;
				end
				if (s.name_pos != hbrr_pkg::POS_MAX) begin
					r.name_pos = s.name_pos + 3'd1;
				end
			end
		end else if (s.line_phase == hbrr_pkg::LP_VALUE) begin
			// leave leading whitespace on the first other byte
			if (vp == hbrr_pkg::VP_LWS && c != hbrr_pkg::CH_SP && c != hbrr_pkg::CH_TAB) begin
				vp = hbrr_pkg::VP_PREFIX;
				pp = 3'd0;
			end
			if (vp == hbrr_pkg::VP_PREFIX) begin
				if (pp >= hbrr_pkg::PFX_LEN || lc != pfx_char(pp)) begin
					r.value_phase = hbrr_pkg::VP_REJECT;
					r.prefix_pos  = pp;
				end else begin
					r.prefix_pos  = pp + 3'd1;
					r.value_phase = (pp + 3'd1 == hbrr_pkg::PFX_LEN) ?
						hbrr_pkg::VP_BODY : hbrr_pkg::VP_PREFIX;
				end
			end else if (vp == hbrr_pkg::VP_BODY) begin
				if (c == hbrr_pkg::CH_COMMA) begin
					r.flags.comma = 1'b1;
				end else if (!s.flags.dash) begin
					if (c == hbrr_pkg::CH_DASH) begin
						r.flags.dash = 1'b1;
					end else begin
						r.flags.a_any = 1'b1;
						if (is_dig) begin
							r.start_value = dec_push(s.start_value, c[3:0]);
						end else begin
							r.flags.a_bad = 1'b1;
						end
					end
				end else begin
					r.flags.b_any = 1'b1;
					if (is_dig) begin
						r.end_value = dec_push(s.end_value, c[3:0]);
					end else begin
						r.flags.b_bad = 1'b1;
					end
				end
			end
		end
		return r;
	endfunction

	// Close a line on CRLF
	function automatic hbrr_pkg::scan_t line_end(input hbrr_pkg::scan_t s);
		hbrr_pkg::scan_t r;
		logic            clr;
		r   = s;
		clr = 1'b1;
		if (s.line_phase == hbrr_pkg::LP_NAME && s.name_pos == 3'd0) begin
			r.line_phase = hbrr_pkg::LP_DONE;
			clr          = 1'b0;
		end else if (s.line_phase == hbrr_pkg::LP_VALUE) begin
			r.committed  = 1'b1;
			r.line_phase = hbrr_pkg::LP_DONE;
			clr          = 1'b0;
		end else begin
			r.line_phase = hbrr_pkg::LP_NAME;
		end
		if (clr) begin
			r.name_pos = 3'd0;
			r.name_mis = 1'b0;
		end
		return r;
	endfunction

	// Reset image of the scanner
	always_comb begin
		st_rst             = '0;
		st_rst.line_phase  = hbrr_pkg::LP_REQ;
		st_rst.value_phase = hbrr_pkg::VP_LWS;
	end

	// Advance the scanner by one byte, folding a held CR in first
	always_comb begin
		hbrr_pkg::scan_t a;
		a    = st_q;
		st_n = st_q;
		cr_n = cr_q;
		if (st_q.line_phase != hbrr_pkg::LP_DONE) begin
			if (cr_q && word.req_byte == hbrr_pkg::CH_LF) begin
				st_n = line_end(st_q);
				cr_n = 1'b0;
			end else begin
				if (cr_q) begin
					a = content_step(st_q, hbrr_pkg::CH_CR);
				end
				if (word.req_byte == hbrr_pkg::CH_CR) begin
					st_n = a;
					cr_n = 1'b1;
				end else begin
					st_n = content_step(a, word.req_byte);
					cr_n = 1'b0;
				end
			end
		end
	end

	// Hold scanner state; return to reset after the final byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= st_rst;
			cr_q <= 1'b0;
		end else if (accept) begin
			if (word.req_end) begin
				st_q <= st_rst;
				cr_q <= 1'b0;
			end else begin
				st_q <= st_n;
				cr_q <= cr_n;
			end
		end
	end

	// Capture the finished value on the final byte
	always_ff @(posedge clk) begin
		if (load_s1) begin
			snap_s1.body_ok     <= st_n.committed && (st_n.value_phase == hbrr_pkg::VP_BODY);
			snap_s1.start_value <= st_n.start_value;
			snap_s1.end_value   <= st_n.end_value;
			snap_s1.flags       <= st_n.flags;
			snap_s1.body_length <= word.body_length;
		end
	end

endmodule

>>> rtl/hbrr_resolve.sv
// Range resolution against the body length, into the result register.
module hbrr_resolve (
	input  logic               clk,
	input  logic               load,
	input  hbrr_pkg::snap_t    snap,
	output hbrr_pkg::hbrr_out_t word_q
);

	logic [hbrr_pkg::LEN_W-1:0] b;
	logic [hbrr_pkg::LEN_W-1:0] b_m1;
	logic [hbrr_pkg::LEN_W-1:0] e_clamp;
	logic                       b_zero;
	hbrr_pkg::value_flags_t     f;
	hbrr_pkg::hbrr_out_t        res;

	assign b       = snap.body_length;
	assign b_zero  = (b == '0);
	assign b_m1    = b - {{(hbrr_pkg::LEN_W-1){1'b0}}, 1'b1};
	assign f       = snap.flags;
	assign e_clamp = (snap.end_value >= b) ? b_m1 : snap.end_value;

	// Work out the range; default to the full body
	always_comb begin
		res.range_first      = '0;
		res.range_last       = b_zero ? '0 : b_m1;
		res.is_partial       = 1'b0;
		res.is_unsatisfiable = 1'b0;
		if (snap.body_ok && !f.comma && f.dash) begin
			if (!f.a_any) begin
				if (f.b_any) begin
					if (f.b_bad || snap.end_value == '0 || b_zero) begin
						res.is_unsatisfiable = 1'b1;
					end else begin
						res.range_first = (snap.end_value >= b) ? '0 : b - snap.end_value;
						res.is_partial  = (snap.end_value < b);
					end
				end
			end else if (!f.a_bad) begin
				if (b_zero || snap.start_value >= b) begin
					res.is_unsatisfiable = 1'b1;
				end else if (!f.b_any) begin
					res.range_first = snap.start_value;
					res.is_partial  = (snap.start_value != '0);
				end else if (!f.b_bad && snap.end_value >= snap.start_value) begin
					res.range_first = snap.start_value;
					res.range_last  = e_clamp;
					res.is_partial  = (snap.start_value != '0) || (e_clamp != b_m1);
				end
			end
		end
	end

	// Hold the result until it is taken
	always_ff @(posedge clk) begin
		if (load) begin
			word_q <= res;
		end
	end

endmodule

>>> rtl/http_byte_range_resolver.sv
// Top level of the HTTP byte range resolver.
//
// The req channel carries one header byte per word, with req_end set on the
// last byte of a request and body_length sampled on that byte. The rsp
// channel carries one resolved range per request: first and last offset,
// a partial flag (206) and an unsatisfiable flag (416). Words without
// req_end give no result.
// A byte is taken every cycle while req_stall is low; the scanner state
// advances in the cycle the byte is accepted. The final byte is captured
// into a snapshot stage at the accepting edge, then resolved and loaded into
// the result register when that register is free; rsp_stall holding a result
// can delay this. rsp_valid rises with the loaded result word.
// Throughput is one byte per cycle while req_stall is low.
// When rsp_stall holds a result, one more final byte may wait in the
// snapshot stage; req_stall rises only when both are full.
// After arst_n the scanner is in the request line and no result is pending;
// after each final byte it returns to that state for the next request.
module http_byte_range_resolver (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_stall,
	input  hbrr_pkg::hbrr_in_t  req,
	output logic                rsp_valid,
	input  logic                rsp_stall,
	output hbrr_pkg::hbrr_out_t rsp
);

	hbrr_pkg::snap_t snap_s1;
	logic            s1_valid_q;
	logic            rsp_valid_q;
	logic            rsp_ready;
	logic            s1_adv;
	logic            accept;
	logic            load_s1;

	// Handshake between the stages
	assign rsp_ready = !rsp_valid_q || !rsp_stall;
	assign s1_adv    = s1_valid_q && rsp_ready;
	assign req_stall = s1_valid_q && !rsp_ready;
	assign accept    = req_valid && !req_stall;
	assign load_s1   = accept && req.req_end;
	assign rsp_valid = rsp_valid_q;

	hbrr_scan u_scan (
		.clk     (clk),
		.arst_n  (arst_n),
		.accept  (accept),
		.word    (req),
		.load_s1 (load_s1),
		.snap_s1 (snap_s1)
	);

	hbrr_resolve u_resolve (
		.clk    (clk),
		.load   (s1_adv),
		.snap   (snap_s1),
		.word_q (rsp)
	);

	// Track which stages hold a word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q  <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (load_s1) begin
				s1_valid_q <= 1'b1;
			end else if (s1_adv) begin
				s1_valid_q <= 1'b0;
			end
			if (rsp_ready) begin
				rsp_valid_q <= s1_valid_q;
			end
		end
	end

endmodule
